// File: src/gcode_extrusion_path_splitter_assert.svh
// ----------------------------------------------------------------------------
// gcode extrusion path splitter assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef GCODE_EXTRUSION_PATH_SPLITTER_ASSERT_SVH
`define GCODE_EXTRUSION_PATH_SPLITTER_ASSERT_SVH

// same-cycle implication
`define GCPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcps assertion failed");

// next-cycle implication
`define GCPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcps assertion failed");

`endif

// File: src/gcps_pkg.sv
// ----------------------------------------------------------------------------
// gcps_pkg
// types and constants shared by the extrusion path splitter modules
// ----------------------------------------------------------------------------
package gcps_pkg;

    localparam int COORD_W        = 32;
    localparam int RUN_COUNT_BITS = 20;
    localparam int SUBPATH_BITS   = 16;

    // word kinds
    localparam logic [2:0] KIND_IGNORE = 3'd0;
    localparam logic [2:0] KIND_G      = 3'd1;
    localparam logic [2:0] KIND_X      = 3'd2;
    localparam logic [2:0] KIND_Y      = 3'd3;
    localparam logic [2:0] KIND_Z      = 3'd4;
    localparam logic [2:0] KIND_EOP    = 3'd5;

    // g codes
    localparam logic [7:0] G_RAPID    = 8'd0;
    localparam logic [7:0] G_LINEAR   = 8'd1;
    localparam logic [7:0] G_ABSOLUTE = 8'd90;
    localparam logic [7:0] G_RELATIVE = 8'd91;

    // result kinds
    localparam logic RES_POINT = 1'b0;
    localparam logic RES_CLOSE = 1'b1;

    // axis indexes
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [RUN_COUNT_BITS-1:0] run_cnt_t;
    typedef logic [SUBPATH_BITS-1:0]   sub_cnt_t;

    typedef struct packed {
        logic [2:0] word_kind;
        logic [7:0] g_number;
        coord_t     coord_value;
        logic       end_of_block;
    } in_word_t;

    typedef struct packed {
        logic     result_kind;
        coord_t   point_x;
        coord_t   point_y;
        coord_t   point_z;
        sub_cnt_t subpath_number;
        run_cnt_t points_in_subpath;
        run_cnt_t most_points;
    } out_word_t;

    // controls shared by the three axis units
    typedef struct packed {
        logic go;
        logic clear;
        logic resolve;
        logic relative;
    } axis_ctl_t;

    // controls for the run tracker
    typedef struct packed {
        logic go;
        logic g_rapid;
        logic g_linear;
        logic eop;
        logic resolve;
    } run_ctl_t;

    // run tracker decision for the current word
    typedef struct packed {
        logic     produce;
        logic     kind;
        sub_cnt_t subpath_number;
        run_cnt_t points;
        run_cnt_t most;
    } run_res_t;

endpackage

// File: src/gcps_axis.sv
// ----------------------------------------------------------------------------
// gcps_axis
// one coordinate axis: pending value of the open block and resolved position
// ----------------------------------------------------------------------------
module gcps_axis (
    input  logic               clk,
    input  logic               rst_n,
    input  gcps_pkg::axis_ctl_t ctl,
    input  logic               wr,
    input  logic               given,
    input  gcps_pkg::coord_t   value,
    output gcps_pkg::coord_t   pos_new
);
    import gcps_pkg::*;

    coord_t pending_reg, pending_next;
    coord_t pos_reg, pos_next;
    coord_t pending_eff;
    logic [COORD_W:0] sum;
    coord_t sum_sat;

    assign pending_eff = wr ? value : pending_reg;

    // saturating relative add
    always_comb
    begin
        sum = {pos_reg[COORD_W-1], pos_reg} + {pending_eff[COORD_W-1], pending_eff};
        if (sum[COORD_W] != sum[COORD_W-1])
        begin
            sum_sat = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                   : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[COORD_W-1:0];
        end
    end

    always_comb
    begin
        if (!given)
            pos_new = pos_reg;
        else if (ctl.relative)
            pos_new = sum_sat;
        else
            pos_new = pending_eff;
    end

    always_comb
    begin
        pending_next = pending_reg;
        pos_next     = pos_reg;
        if (ctl.go)
        begin
            pending_next = ctl.clear ? '0 : pending_eff;
            if (ctl.resolve)
                pos_next = pos_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// File: src/gcps_run.sv
// ----------------------------------------------------------------------------
// gcps_run
// extrusion state, run length, sub-path count and longest run
// ----------------------------------------------------------------------------
module gcps_run (
    input  logic               clk,
    input  logic               rst_n,
    input  gcps_pkg::run_ctl_t ctl,
    output gcps_pkg::run_res_t res
);
    import gcps_pkg::*;

    localparam run_cnt_t RUN_MAX = {RUN_COUNT_BITS{1'b1}};
    localparam sub_cnt_t SUB_MAX = {SUBPATH_BITS{1'b1}};

    logic     extruding_reg, extruding_next;
    run_cnt_t run_len_reg, run_len_next;
    sub_cnt_t sub_cnt_reg, sub_cnt_next;
    run_cnt_t longest_reg, longest_next;

    logic     close_req, closing, point, extruding_after;
    run_cnt_t run_inc, longest_upd;

    assign close_req       = ctl.eop || (ctl.g_rapid && extruding_reg);
    assign closing         = close_req && (run_len_reg != '0);
    assign extruding_after = ctl.g_linear || (extruding_reg && !ctl.g_rapid && !ctl.eop);
    assign point           = ctl.resolve && extruding_after && !closing;
    assign run_inc         = (run_len_reg == RUN_MAX) ? run_len_reg : run_len_reg + 1'b1;
    assign longest_upd     = (run_len_reg > longest_reg) ? run_len_reg : longest_reg;

    always_comb
    begin
        res.produce        = closing || point;
        res.kind           = closing ? RES_CLOSE : RES_POINT;
        res.subpath_number = sub_cnt_reg;
        res.points         = closing ? run_len_reg : run_inc;
        res.most           = closing ? longest_upd : longest_reg;
    end

    always_comb
    begin
        extruding_next = extruding_reg;
        run_len_next   = run_len_reg;
        sub_cnt_next   = sub_cnt_reg;
        longest_next   = longest_reg;
        if (ctl.go)
        begin
            extruding_next = extruding_after;
            if (closing)
            begin
                run_len_next = '0;
                longest_next = longest_upd;
                sub_cnt_next = (sub_cnt_reg == SUB_MAX) ? sub_cnt_reg : sub_cnt_reg + 1'b1;
            end
            else if (point)
            begin
                run_len_next = run_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extruding_reg <= 1'b0;
            run_len_reg   <= '0;
            sub_cnt_reg   <= '0;
            longest_reg   <= '0;
        end
        else
        begin
            extruding_reg <= extruding_next;
            run_len_reg   <= run_len_next;
            sub_cnt_reg   <= sub_cnt_next;
            longest_reg   <= longest_next;
        end
    end

endmodule

// File: src/gcode_extrusion_path_splitter.sv
// ----------------------------------------------------------------------------
// gcode_extrusion_path_splitter
// splits a stream of parsed g-code words into extruded path points and
// sub-path close words
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  word     | word_valid / word_stall    | gcps_pkg::in_word_t  word_data
//  result   | result_valid / result_stall| gcps_pkg::out_word_t result_data
//
//  one word per cycle sustained while the result is not stalled; a word
//  is held in the input register and its result (if any) is loaded into
//  the result register as the word goes through, which raises result_valid
//  the decode, the saturating axis adders and the run counters sit in one
//  combinational pass between the input register and the result register
//  reset clears the position, modes, counters and both valid bits
//  a stalled result holds the input register; word_stall then rises only
//  while the input register is full
// ----------------------------------------------------------------------------
module gcode_extrusion_path_splitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    input  gcps_pkg::in_word_t  word_data,
    output logic                word_stall,
    output logic                result_valid,
    input  logic                result_stall,
    output gcps_pkg::out_word_t result_data
);
    import gcps_pkg::*;

    // input register
    logic     in_valid_reg, in_valid_next;
    in_word_t in_word_reg;

    // result register
    logic      result_valid_reg, result_valid_next;
    out_word_t result_data_reg;

    // modal distance mode and block axis flags
    logic       relative_reg, relative_next;
    logic [2:0] given_reg, given_next;

    logic       out_free, proc_go, word_go;
    logic       is_g, is_eop, g_rapid, g_linear, g_abs, g_rel;
    logic [2:0] axis_wr, given_eff;
    logic       eob_eff, resolve, relative_eff;

    axis_ctl_t axis_ctl;
    run_ctl_t  run_ctl;
    run_res_t  run_res;
    coord_t    pos_x_new, pos_y_new, pos_z_new;

    // close word on the output and its longest-run check
    logic       close_shown, close_covered;

    // handshake: result register frees when empty or being taken
    assign out_free   = !result_valid_reg || !result_stall;
    assign proc_go    = in_valid_reg && out_free;
    assign word_stall = in_valid_reg && !out_free;
    assign word_go    = word_valid && !word_stall;

    // word decode
    assign is_g     = (in_word_reg.word_kind == KIND_G);
    assign is_eop   = (in_word_reg.word_kind == KIND_EOP);
    assign g_rapid  = is_g && (in_word_reg.g_number == G_RAPID);
    assign g_linear = is_g && (in_word_reg.g_number == G_LINEAR);
    assign g_abs    = is_g && (in_word_reg.g_number == G_ABSOLUTE);
    assign g_rel    = is_g && (in_word_reg.g_number == G_RELATIVE);

    always_comb
    begin
        axis_wr         = '0;
        axis_wr[AXIS_X] = (in_word_reg.word_kind == KIND_X);
        axis_wr[AXIS_Y] = (in_word_reg.word_kind == KIND_Y);
        axis_wr[AXIS_Z] = (in_word_reg.word_kind == KIND_Z);
    end

    // end of program drops the open block, so its end-of-block flag is moot
    assign given_eff    = given_reg | axis_wr;
    assign eob_eff      = in_word_reg.end_of_block && !is_eop;
    assign resolve      = eob_eff && (given_eff != '0);
    // a mode change in the last word of a block applies to that block
    assign relative_eff = g_rel ? 1'b1 : (g_abs ? 1'b0 : relative_reg);

    always_comb
    begin
        relative_next = relative_reg;
        given_next    = given_reg;
        if (proc_go)
        begin
            relative_next = relative_eff;
            given_next    = (is_eop || in_word_reg.end_of_block) ? 3'b000 : given_eff;
        end
    end

    assign axis_ctl = '{go:       proc_go,
                        clear:    is_eop || in_word_reg.end_of_block,
                        resolve:  resolve,
                        relative: relative_eff};

    assign run_ctl = '{go:       proc_go,
                       g_rapid:  g_rapid,
                       g_linear: g_linear,
                       eop:      is_eop,
                       resolve:  resolve};

    gcps_axis u_axis_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (axis_ctl),
        .wr      (axis_wr[AXIS_X]),
        .given   (given_eff[AXIS_X]),
        .value   (in_word_reg.coord_value),
        .pos_new (pos_x_new)
    );

    gcps_axis u_axis_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (axis_ctl),
        .wr      (axis_wr[AXIS_Y]),
        .given   (given_eff[AXIS_Y]),
        .value   (in_word_reg.coord_value),
        .pos_new (pos_y_new)
    );

    gcps_axis u_axis_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (axis_ctl),
        .wr      (axis_wr[AXIS_Z]),
        .given   (given_eff[AXIS_Z]),
        .value   (in_word_reg.coord_value),
        .pos_new (pos_z_new)
    );

    gcps_run u_run (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (run_ctl),
        .res   (run_res)
    );

    // valid bits
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (proc_go)
            in_valid_next = 1'b0;
        if (word_go)
            in_valid_next = 1'b1;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        if (proc_go && run_res.produce)
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            relative_reg     <= 1'b0;
            given_reg        <= 3'b000;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
            relative_reg     <= relative_next;
            given_reg        <= given_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (word_go)
            in_word_reg <= word_data;
        if (proc_go && run_res.produce)
        begin
            result_data_reg.result_kind       <= run_res.kind;
            // a close word carries no coordinates
            result_data_reg.point_x           <= (run_res.kind == RES_CLOSE) ? '0 : pos_x_new;
            result_data_reg.point_y           <= (run_res.kind == RES_CLOSE) ? '0 : pos_y_new;
            result_data_reg.point_z           <= (run_res.kind == RES_CLOSE) ? '0 : pos_z_new;
            result_data_reg.subpath_number    <= run_res.subpath_number;
            result_data_reg.points_in_subpath <= run_res.points;
            result_data_reg.most_points       <= run_res.most;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    `include "gcode_extrusion_path_splitter_assert.svh"

    assign close_shown   = result_valid && (result_data.result_kind == RES_CLOSE);
    assign close_covered = (result_data.most_points >= result_data.points_in_subpath);

    // a closed sub-path is never empty
    `GCPS_ASSERT_NOW(a_close_nonempty, close_shown, result_data.points_in_subpath != '0)
    // the longest run covers the run just closed
    `GCPS_ASSERT_NOW(a_close_longest, close_shown, close_covered)
    // input stall only while the input register holds a word
    `GCPS_ASSERT_NOW(a_stall_full, word_stall, in_valid_reg && result_valid_reg)
    // a word that goes through with a result leaves a valid result behind
    `GCPS_ASSERT_NEXT(a_result_follows, proc_go && run_res.produce, result_valid)

endmodule
